// ===== src/base_relocation_patcher_unit_defines.svh =====
// Assertion macros used by the checker of the relocation patcher.
`ifndef BASE_RELOCATION_PATCHER_UNIT_DEFINES_SVH
`define BASE_RELOCATION_PATCHER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define BRP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("brp assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define BRP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("brp assertion failed");

`endif

// ===== src/brp_pkg.sv =====
// Shared types, codes and Thumb-2 immediate helpers for the relocation patcher.
package brp_pkg;

    localparam int unsigned AddrWidth   = 3;
    localparam int unsigned InDataWidth  = 144;
    localparam int unsigned OutDataWidth = 136;

    localparam logic [31:0] HdrBytes = 32'd8;
    localparam logic [31:0] SatMax   = 32'hFFFF_FFFF;

    // MOVW/MOVT immediate bit positions in the first and second halfword
    localparam logic [15:0] ImmMaskA = 16'h040F;
    localparam logic [15:0] ImmMaskB = 16'h70FF;

    // register index taken from paddr[AddrWidth-1]
    localparam logic REG_LOAD_DELTA = 1'b0;
    localparam logic REG_DIR_BYTES  = 1'b1;

    localparam logic OP_HEADER = 1'b0;
    localparam logic OP_ENTRY  = 1'b1;

    localparam logic [3:0] REL_HIGHLOW = 4'd3;
    localparam logic [3:0] REL_MOV32T  = 4'd5;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_IGNORED = 2'd1,
        STATUS_STOPPED = 2'd2
    } status_t;

    typedef struct packed {
        logic [31:0] load_delta;
        logic [31:0] directory_bytes;
    } cfg_t;

    // first listed field lands in the high bits, so page_rva is at bit 0
    typedef struct packed {
        logic [31:0] second_word;
        logic [31:0] first_word;
        logic [15:0] entry_word;
        logic [31:0] block_size;
        logic [31:0] page_rva;
    } req_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] applied_total;
        logic [1:0]  words_written;
        logic [31:0] new_second_word;
        logic [31:0] new_first_word;
        logic [31:0] target_rva;
    } rsp_t;

    localparam int unsigned RspWidth = $bits(rsp_t);

    // gather imm16 from a MOVW/MOVT word (low halfword first)
    function automatic logic [15:0] imm16_get(input logic [31:0] word);
        logic [15:0] a;
        logic [15:0] b;
        a = word[15:0];
        b = word[31:16];
        return {a[3:0], a[10], b[14:12], b[7:0]};
    endfunction

    function automatic logic [31:0] imm16_put(input logic [31:0] word,
                                              input logic [15:0] imm);
        logic [15:0] a;
        logic [15:0] b;
        a = word[15:0] & ~ImmMaskA;
        b = word[31:16] & ~ImmMaskB;
        a[3:0]   = imm[15:12];
        a[10]    = imm[11];
        b[7:0]   = imm[7:0];
        b[14:12] = imm[10:8];
        return {b, a};
    endfunction

endpackage

// ===== src/brp_cfg_regs.sv =====
// APB register file holding the load delta and the directory size.
module brp_cfg_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [brp_pkg::AddrWidth-1:0]     paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    output brp_pkg::cfg_t                     cfg
);

    brp_pkg::cfg_t cfg_reg;
    logic          reg_sel;
    logic          wr_en;

    assign pready  = 1'b1;
    assign reg_sel = paddr[brp_pkg::AddrWidth-1];
    assign wr_en   = psel & penable & pwrite & pready;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                brp_pkg::REG_LOAD_DELTA: cfg_reg.load_delta      <= pwdata;
                brp_pkg::REG_DIR_BYTES:  cfg_reg.directory_bytes <= pwdata;
                default:                 cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            brp_pkg::REG_LOAD_DELTA: prdata = cfg_reg.load_delta;
            brp_pkg::REG_DIR_BYTES:  prdata = cfg_reg.directory_bytes;
            default:                 prdata = '0;
        endcase
    end

endmodule

// ===== src/brp_in_stage.sv =====
// Input register: one slave-stream request per cycle unless core stalls.
module brp_in_stage (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic          in_op,
    input  brp_pkg::req_t in_req,
    output logic          req_valid,
    output logic          req_op,
    output brp_pkg::req_t req,
    input  logic          req_take
);

    logic          valid_reg;
    logic          valid_next;
    logic          op_reg;
    brp_pkg::req_t req_reg;
    logic          load;

    assign in_ready   = !valid_reg || req_take;
    assign load       = in_valid && in_ready;
    assign valid_next = load || (valid_reg && !req_take);

    assign req_valid = valid_reg;
    assign req_op    = op_reg;
    assign req       = req_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            op_reg  <= in_op;
            req_reg <= in_req;
        end
    end

endmodule

// ===== src/brp_core.sv =====
// Walk state, patch logic and result register.
module brp_core (
    input  logic          clk,
    input  logic          rst_n,
    input  brp_pkg::cfg_t cfg,
    input  logic          req_valid,
    input  logic          req_op,
    input  brp_pkg::req_t req,
    output logic          req_take,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output brp_pkg::rsp_t rsp
);

    logic [31:0]   page_base_reg,      page_base_next;
    logic [30:0]   entries_left_reg,   entries_left_next;
    logic [31:0]   bytes_consumed_reg, bytes_consumed_next;
    logic          walk_stopped_reg,   walk_stopped_next;
    logic [31:0]   applied_count_reg,  applied_count_next;
    logic          rsp_valid_reg,      rsp_valid_next;
    brp_pkg::rsp_t rsp_reg,            rsp_next;

    logic [3:0]  rel_type;
    logic [31:0] entry_target;
    logic [32:0] consumed_sum;
    logic [31:0] body_bytes;
    logic        hdr_ok;
    logic        delta_nz;
    logic        is_mov32t;
    logic [31:0] addend;
    logic [31:0] patched;

    assign req_take  = req_valid && (!rsp_valid_reg || rsp_ready);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign rel_type     = req.entry_word[15:12];
    assign entry_target = page_base_reg + {20'd0, req.entry_word[11:0]};
    assign consumed_sum = {1'b0, bytes_consumed_reg} + {1'b0, req.block_size};
    assign body_bytes   = req.block_size - brp_pkg::HdrBytes;
    assign hdr_ok       = (bytes_consumed_reg < cfg.directory_bytes)
                          && (req.block_size > brp_pkg::HdrBytes);
    assign delta_nz     = cfg.load_delta != '0;
    assign is_mov32t    = rel_type == brp_pkg::REL_MOV32T;

    // one adder serves both HIGHLOW and MOV32T
    assign addend  = is_mov32t ? {brp_pkg::imm16_get(req.second_word),
                                  brp_pkg::imm16_get(req.first_word)}
                               : req.first_word;
    assign patched = addend + cfg.load_delta;

    always_comb
    begin
        page_base_next      = page_base_reg;
        entries_left_next   = entries_left_reg;
        bytes_consumed_next = bytes_consumed_reg;
        walk_stopped_next   = walk_stopped_reg;
        applied_count_next  = applied_count_reg;

        rsp_next.target_rva      = req.page_rva;
        rsp_next.new_first_word  = req.first_word;
        rsp_next.new_second_word = req.second_word;
        rsp_next.words_written   = 2'd0;
        rsp_next.status          = brp_pkg::STATUS_IGNORED;

        if (walk_stopped_reg)
        begin
            rsp_next.status = brp_pkg::STATUS_STOPPED;
            if (req_op == brp_pkg::OP_ENTRY)
            begin
                rsp_next.target_rva = entry_target;
            end
        end
        else if (req_op == brp_pkg::OP_HEADER)
        begin
            if (hdr_ok)
            begin
                page_base_next      = req.page_rva;
                entries_left_next   = body_bytes[31:1];
                bytes_consumed_next = consumed_sum[32] ? brp_pkg::SatMax
                                                       : consumed_sum[31:0];
                rsp_next.status     = brp_pkg::STATUS_OK;
            end
            else
            begin
                walk_stopped_next = 1'b1;
                entries_left_next = '0;
                rsp_next.status   = brp_pkg::STATUS_STOPPED;
            end
        end
        else
        begin
            rsp_next.target_rva = entry_target;
            if (entries_left_reg != '0)
            begin
                entries_left_next = entries_left_reg - 31'd1;
                if (delta_nz && rel_type == brp_pkg::REL_HIGHLOW)
                begin
                    rsp_next.new_first_word = patched;
                    rsp_next.words_written  = 2'd1;
                    rsp_next.status         = brp_pkg::STATUS_OK;
                    applied_count_next      = applied_count_reg + 32'd1;
                end
                else if (delta_nz && is_mov32t)
                begin
                    rsp_next.new_first_word  = brp_pkg::imm16_put(req.first_word,
                                                                  patched[15:0]);
                    rsp_next.new_second_word = brp_pkg::imm16_put(req.second_word,
                                                                  patched[31:16]);
                    rsp_next.words_written   = 2'd2;
                    rsp_next.status          = brp_pkg::STATUS_OK;
                    applied_count_next       = applied_count_reg + 32'd1;
                end
            end
        end

        rsp_next.applied_total = applied_count_next;
    end

    assign rsp_valid_next = req_take || (rsp_valid_reg && !rsp_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_base_reg      <= '0;
            entries_left_reg   <= '0;
            bytes_consumed_reg <= '0;
            walk_stopped_reg   <= 1'b0;
            applied_count_reg  <= '0;
            rsp_valid_reg      <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            if (req_take)
            begin
                page_base_reg      <= page_base_next;
                entries_left_reg   <= entries_left_next;
                bytes_consumed_reg <= bytes_consumed_next;
                walk_stopped_reg   <= walk_stopped_next;
                applied_count_reg  <= applied_count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            rsp_reg <= rsp_next;
        end
    end

endmodule

// ===== src/base_relocation_patcher_unit.sv =====
// Top level of the PE base-relocation patcher (HIGHLOW and ARM MOV32T).
//
// Requests enter on the s_axis group: tuser is the operation (0 block
// header, 1 relocation entry) and tdata carries the header fields and the
// entry with the one or two target words. One response per request leaves
// on the m_axis group with the target RVA, the patched words, the count of
// words to write back, the running applied count and a status code.
// load_delta and directory_bytes sit on the APB port at 0x0 and 0x4; write
// them only while no request is in flight.
// A request is held in the input register, then passes through the patch
// logic into the response register. Throughput is one request per cycle
// while the response register is empty or m_axis_tready is high; a single
// 32-bit delta adder sits between the two registers. Reset clears the
// walk state, the applied count and the valid bits of both registers.
// When m_axis_tready is low the response register holds; the input register
// still takes one request if it is empty, then s_axis_tready drops, so at
// most two requests wait.
module base_relocation_patcher_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [brp_pkg::AddrWidth-1:0]       paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [31:0] page_rva, [63:32] block_size, [79:64] entry_word,
    // [111:80] first_word, [143:112] second_word
    input  logic [brp_pkg::InDataWidth-1:0]     s_axis_tdata,
    // [0] operation
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [31:0] target_rva, [63:32] new_first_word, [95:64] new_second_word,
    // [97:96] words_written, [129:98] applied_total, [131:130] status
    output logic [brp_pkg::OutDataWidth-1:0]    m_axis_tdata
);

    brp_pkg::cfg_t cfg;
    brp_pkg::req_t req;
    brp_pkg::rsp_t rsp;
    logic          req_valid;
    logic          req_op;
    logic          req_take;

    brp_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    brp_in_stage u_in (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_op     (s_axis_tuser),
        .in_req    (brp_pkg::req_t'(s_axis_tdata)),
        .req_valid (req_valid),
        .req_op    (req_op),
        .req       (req),
        .req_take  (req_take)
    );

    brp_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .req_valid (req_valid),
        .req_op    (req_op),
        .req       (req),
        .req_take  (req_take),
        .rsp_valid (m_axis_tvalid),
        .rsp_ready (m_axis_tready),
        .rsp       (rsp)
    );

    assign m_axis_tdata = {{(brp_pkg::OutDataWidth - brp_pkg::RspWidth){1'b0}}, rsp};

endmodule

// ===== src/brp_checker.sv =====
// Port-level checks on the patcher response stream, bound to the top level.
`include "base_relocation_patcher_unit_defines.svh"

module brp_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [brp_pkg::OutDataWidth-1:0] m_axis_tdata
);

    brp_pkg::rsp_t rsp;
    logic          stalled;

    assign rsp     = m_axis_tdata[brp_pkg::RspWidth-1:0];
    assign stalled = m_axis_tvalid && !m_axis_tready;

    `BRP_ASSERT_NEXT(a_valid_held, stalled, m_axis_tvalid)
    `BRP_ASSERT_NEXT(a_data_held, stalled, $stable(m_axis_tdata))
    // writes happen only for an applied relocation
    `BRP_ASSERT_NOW(a_write_needs_ok, m_axis_tvalid && rsp.words_written != 2'd0,
        rsp.status == brp_pkg::STATUS_OK && rsp.words_written != 2'd3)
    `BRP_ASSERT_NOW(a_status_legal, m_axis_tvalid,
        rsp.status == brp_pkg::STATUS_OK || rsp.status == brp_pkg::STATUS_IGNORED
        || rsp.status == brp_pkg::STATUS_STOPPED)

endmodule

bind base_relocation_patcher_unit brp_checker u_brp_checker (.*);
